// ----- sv/ght_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the generational handle table.
package ght_pkg;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_BAD       = 2'd2;

   localparam int MAP_WORD_BITS = 32;

   typedef struct packed {
      logic [15:0] gen;
      logic [7:0]  kind;
      logic [15:0] rights;
      logic [31:0] fd;
      logic        has_fd;
   } slot_entry_type;

   typedef struct packed {
      logic           rd_en;
      logic [15:0]    rd_idx;
      logic           wr_en;
      logic [15:0]    wr_idx;
      slot_entry_type wr_data;
   } slot_cmd_type;

   typedef struct packed {
      logic        rd_en;
      logic [15:0] rd_word;
      logic        wr_en;
      logic [15:0] wr_word;
      logic [31:0] wr_data;
   } map_cmd_type;

   typedef struct packed {
      logic [31:0] data;
      logic [15:0] word;
      logic        found;
      logic [4:0]  bit_pos;
   } map_rsp_type;

endpackage

// ----- sv/generational_handle_table.sv -----
`timescale 1ns / 1ps
// Generational handle table. A transaction is taken when start is high and busy is low; its
// single result appears on the rsp_ ports for exactly one cycle with rsp_valid high and
// cannot be held off, so the receiver must capture it then. Lookup and free do one slot and
// bitmap read, then check and write back. Allocate reads one 32-slot bitmap word at a time,
// moving on past every completely used word, starting at the lowest word that can hold a free
// slot; it then reads the found slot and writes the slot and its bitmap word back.
// After reset busy stays high while the memories are cleared.
module generational_handle_table
   import ght_pkg::*;
#(
   parameter int TABLE_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_handle,
   input  logic [7:0]  req_want_kind,
   input  logic        req_check_kind,
   input  logic [15:0] req_rights,
   input  logic [31:0] req_fd_value,
   input  logic        req_fd_present,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_handle_out,
   output logic [7:0]  rsp_kind_out,
   output logic [15:0] rsp_rights_out,
   output logic [31:0] rsp_fd_out,
   output logic        rsp_fd_valid
);

   localparam int IDX_W   = $clog2(TABLE_SLOTS);
   localparam int NW      = (TABLE_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WADDR_W = (NW > 1) ? $clog2(NW) : 1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_ALLOC = 5'b01000,
      ST_CHECK = 5'b10000
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] handle;
      logic [7:0]  want_kind;
      logic        check_kind;
      logic [15:0] rights;
      logic [31:0] fd_value;
      logic        fd_present;
   } req_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [WADDR_W-1:0] hint_ff, hint_in;
   req_type          req_ff, req_in;
   logic [15:0]      alloc_idx_ff, alloc_idx_in;
   logic [31:0]      alloc_word_ff, alloc_word_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_handle_ff, rsp_handle_in;
   logic [7:0]  rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_rights_ff, rsp_rights_in;
   logic [31:0] rsp_fd_ff, rsp_fd_in;
   logic        rsp_fd_valid_ff, rsp_fd_valid_in;

   slot_cmd_type   slot_cmd;
   slot_entry_type slot_rd;
   map_cmd_type    map_cmd;
   map_rsp_type    map_rsp;

   ght_slot_store #(.TABLE_SLOTS(TABLE_SLOTS)) u_slots (
      .clock   (clock),
      .cmd     (slot_cmd),
      .rd_data (slot_rd)
   );

   ght_free_map #(.TABLE_SLOTS(TABLE_SLOTS)) u_map (
      .clock (clock),
      .cmd   (map_cmd),
      .rsp   (map_rsp)
   );

   logic [15:0] in_idx;
   logic        in_range_in;
   logic [15:0] chk_idx;
   logic        chk_in_range;
   logic        chk_used;
   logic        chk_ok;
   logic [15:0] chk_word;
   logic [15:0] found_idx;
   logic [31:0] bit_mask;

   always_comb begin
      in_idx       = req_handle[15:0];
      in_range_in  = {1'b0, in_idx} < 17'(TABLE_SLOTS);
      chk_idx      = req_ff.handle[15:0];
      chk_in_range = {1'b0, chk_idx} < 17'(TABLE_SLOTS);
      chk_word     = chk_idx >> 5;
      chk_used     = map_rsp.data[chk_idx[4:0]];
      chk_ok       = ((req_ff.op == OP_LOOKUP) || (req_ff.op == OP_FREE))
                     && chk_in_range && (chk_idx != 16'd0) && chk_used
                     && (slot_rd.gen == req_ff.handle[31:16])
                     && !((req_ff.op == OP_LOOKUP) && req_ff.check_kind
                          && (slot_rd.kind != req_ff.want_kind));
      found_idx    = (map_rsp.word << 5) | 16'(map_rsp.bit_pos);
      bit_mask     = 32'd1 << map_rsp.bit_pos;

      state_in      = state_ff;
      clr_in        = clr_ff;
      hint_in       = hint_ff;
      req_in        = req_ff;
      alloc_idx_in  = alloc_idx_ff;
      alloc_word_in = alloc_word_ff;

      rsp_valid_in    = 1'b0;
      rsp_status_in   = STATUS_OK;
      rsp_handle_in   = 32'd0;
      rsp_kind_in     = 8'd0;
      rsp_rights_in   = 16'd0;
      rsp_fd_in       = 32'd0;
      rsp_fd_valid_in = 1'b0;

      slot_cmd = '0;
      map_cmd  = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            slot_cmd.wr_en  = 1'b1;
            slot_cmd.wr_idx = 16'(clr_ff);
            map_cmd.wr_en   = 1'b1;
            map_cmd.wr_word = 16'(clr_ff) >> 5;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in = '{req_op, req_handle, req_want_kind, req_check_kind,
                          req_rights, req_fd_value, req_fd_present};
               map_cmd.rd_en = 1'b1;
               if (req_op == OP_ALLOC) begin
                  map_cmd.rd_word = 16'(hint_ff);
                  state_in        = ST_SCAN;
               end else begin
                  slot_cmd.rd_en  = 1'b1;
                  slot_cmd.rd_idx = in_range_in ? in_idx : 16'd0;
                  map_cmd.rd_word = in_range_in ? (in_idx >> 5) : 16'd0;
                  state_in        = ST_CHECK;
               end
            end
         end
         ST_SCAN: begin
            if (map_rsp.found) begin
               alloc_idx_in    = found_idx;
               alloc_word_in   = map_rsp.data | bit_mask;
               slot_cmd.rd_en  = 1'b1;
               slot_cmd.rd_idx = found_idx;
               state_in        = ST_ALLOC;
            end else if (map_rsp.word == 16'(NW - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_EXHAUSTED;
               state_in      = ST_IDLE;
            end else begin
               // no free slot below the next word: move the hint up with the scan
               map_cmd.rd_en   = 1'b1;
               map_cmd.rd_word = map_rsp.word + 16'd1;
               hint_in         = WADDR_W'(map_rsp.word + 16'd1);
            end
         end
         ST_ALLOC: begin
            slot_cmd.wr_en          = 1'b1;
            slot_cmd.wr_idx         = alloc_idx_ff;
            slot_cmd.wr_data.gen    = slot_rd.gen;
            slot_cmd.wr_data.kind   = req_ff.want_kind;
            slot_cmd.wr_data.rights = req_ff.rights;
            slot_cmd.wr_data.fd     = req_ff.fd_present ? req_ff.fd_value : 32'd0;
            slot_cmd.wr_data.has_fd = req_ff.fd_present;
            map_cmd.wr_en           = 1'b1;
            map_cmd.wr_word         = alloc_idx_ff >> 5;
            map_cmd.wr_data         = alloc_word_ff;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_OK;
            rsp_handle_in   = {slot_rd.gen, alloc_idx_ff};
            rsp_kind_in     = req_ff.want_kind;
            rsp_rights_in   = req_ff.rights;
            rsp_fd_in       = req_ff.fd_present ? req_ff.fd_value : 32'd0;
            rsp_fd_valid_in = req_ff.fd_present;
            state_in        = ST_IDLE;
         end
         ST_CHECK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (chk_ok) begin
               rsp_status_in   = STATUS_OK;
               rsp_handle_in   = req_ff.handle;
               rsp_kind_in     = slot_rd.kind;
               rsp_rights_in   = slot_rd.rights;
               rsp_fd_in       = slot_rd.has_fd ? slot_rd.fd : 32'd0;
               rsp_fd_valid_in = slot_rd.has_fd;
               if (req_ff.op == OP_FREE) begin
                  slot_cmd.wr_en       = 1'b1;
                  slot_cmd.wr_idx      = chk_idx;
                  slot_cmd.wr_data.gen = slot_rd.gen + 16'd1;
                  map_cmd.wr_en        = 1'b1;
                  map_cmd.wr_word      = chk_word;
                  map_cmd.wr_data      = map_rsp.data & ~(32'd1 << chk_idx[4:0]);
                  if (chk_word < 16'(hint_ff)) begin
                     hint_in = WADDR_W'(chk_word);
                  end
               end
            end else begin
               rsp_status_in = STATUS_BAD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      alloc_idx_ff    <= alloc_idx_in;
      alloc_word_ff   <= alloc_word_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_handle_ff   <= rsp_handle_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_rights_ff   <= rsp_rights_in;
      rsp_fd_ff       <= rsp_fd_in;
      rsp_fd_valid_ff <= rsp_fd_valid_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_kind_out   = rsp_kind_ff;
   assign rsp_rights_out = rsp_rights_ff;
   assign rsp_fd_out     = rsp_fd_ff;
   assign rsp_fd_valid   = rsp_fd_valid_ff;

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start work");

   a_ok_nonzero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_OK)) |-> (rsp_handle_out[15:0] != 16'd0))
      else $error("slot 0 reported as valid");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         ((rsp_handle_out == 32'd0) && (rsp_fd_valid == 1'b0) && (rsp_fd_out == 32'd0)))
      else $error("failed transaction carries slot data");

   a_hint_in_table: assert property (@(posedge clock) disable iff (reset)
      16'(hint_ff) <= 16'(NW - 1))
      else $error("scan hint beyond last bitmap word");

endmodule

// ----- sv/ght_slot_store.sv -----
`timescale 1ns / 1ps
// Slot memory: generation, kind, rights and descriptor per slot, registered read.
module ght_slot_store
   import ght_pkg::*;
#(
   parameter int TABLE_SLOTS = 256
) (
   input  logic           clock,
   input  slot_cmd_type   cmd,
   output slot_entry_type rd_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   slot_entry_type mem [TABLE_SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx[IDX_W-1:0]] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_idx[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ght_free_map.sv -----
`timescale 1ns / 1ps
// Used-slot bitmap memory, 32 slots per word, with lowest-free search on the read word.
module ght_free_map
   import ght_pkg::*;
#(
   parameter int TABLE_SLOTS = 256
) (
   input  logic        clock,
   input  map_cmd_type cmd,
   output map_rsp_type rsp
);

   localparam int NW        = (TABLE_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WADDR_W   = (NW > 1) ? $clog2(NW) : 1;
   localparam int LAST_BITS = TABLE_SLOTS - (NW - 1) * MAP_WORD_BITS;
   localparam logic [31:0] LAST_MASK =
      (LAST_BITS == 32) ? {32{1'b1}} : ((32'd1 << LAST_BITS) - 32'd1);

   logic [31:0] mem [NW];
   logic [31:0] rd_data_ff;
   logic [15:0] rd_word_ff;
   logic [31:0] mask;
   logic [31:0] free_bits;
   logic [4:0]  first_free;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_word[WADDR_W-1:0]] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_word[WADDR_W-1:0]];
         rd_word_ff <= cmd.rd_word;
      end
   end

   // slot 0 is never handed out; slots past the table end do not exist
   always_comb begin
      mask = {32{1'b1}};
      if (rd_word_ff == 16'(NW - 1)) begin
         mask = mask & LAST_MASK;
      end
      if (rd_word_ff == 16'd0) begin
         mask[0] = 1'b0;
      end
      free_bits  = ~rd_data_ff & mask;
      first_free = 5'd0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            first_free = 5'(i);
         end
      end
   end

   assign rsp.data    = rd_data_ff;
   assign rsp.word    = rd_word_ff;
   assign rsp.found   = |free_bits;
   assign rsp.bit_pos = first_free;

endmodule

// ----- sim/tb_generational_handle_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the generational handle table: queued driver, monitor, predictor.
module tb_generational_handle_table;
   import ght_pkg::*;

   localparam int SLOTS = 256;
   localparam int RANDOM_ITEMS = 1200;
   localparam int REUSE_PAIRS = 36;
   localparam int TAIL_CYCLES = 32;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] handle;
      logic [7:0]  want_kind;
      logic        check_kind;
      logic [15:0] rights;
      logic [31:0] fd_value;
      logic        fd_present;
   } ght_cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] handle;
      logic [7:0]  kind;
      logic [15:0] rights;
      logic [31:0] fd;
      logic        fd_valid;
   } ght_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = OP_ALLOC;
   logic [31:0] req_handle = '0;
   logic [7:0]  req_want_kind = '0;
   logic        req_check_kind = 1'b0;
   logic [15:0] req_rights = '0;
   logic [31:0] req_fd_value = '0;
   logic        req_fd_present = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_handle_out;
   logic [7:0]  rsp_kind_out;
   logic [15:0] rsp_rights_out;
   logic [31:0] rsp_fd_out;
   logic        rsp_fd_valid;

   generational_handle_table #(
      .TABLE_SLOTS(SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_handle(req_handle),
      .req_want_kind(req_want_kind),
      .req_check_kind(req_check_kind),
      .req_rights(req_rights),
      .req_fd_value(req_fd_value),
      .req_fd_present(req_fd_present),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_handle_out(rsp_handle_out),
      .rsp_kind_out(rsp_kind_out),
      .rsp_rights_out(rsp_rights_out),
      .rsp_fd_out(rsp_fd_out),
      .rsp_fd_valid(rsp_fd_valid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the slot table
   logic        tbl_used   [SLOTS];
   logic [15:0] tbl_gen    [SLOTS];
   logic [7:0]  tbl_kind   [SLOTS];
   logic [15:0] tbl_rights [SLOTS];
   logic [31:0] tbl_fd     [SLOTS];
   logic        tbl_has_fd [SLOTS];

   ght_cmd_type   cmd_q[$];
   ght_reply_type reply_q[$];
   int            live_q[$];
   ght_cmd_type   drv_cmd = '0;

   int burst_left = 1;
   int gap_left = 0;
   bit steady = 1'b0;
   int n_errors = 0;
   int n_accepted = 0;
   int n_ok = 0;
   int n_exhausted = 0;
   int n_bad = 0;
   int unsigned cycle_count = 0;

   function automatic int valid_slot(input logic [31:0] h);
      int idx;
      idx = int'(h[15:0]);
      if (idx == 0 || idx >= SLOTS) return 0;
      if (!tbl_used[idx] || tbl_gen[idx] != h[31:16]) return 0;
      return idx;
   endfunction

   function automatic ght_reply_type slot_contents(input int idx);
      ght_reply_type r;
      r = '0;
      r.status = STATUS_OK;
      r.handle = {tbl_gen[idx], idx[15:0]};
      r.kind = tbl_kind[idx];
      r.rights = tbl_rights[idx];
      r.fd = tbl_has_fd[idx] ? tbl_fd[idx] : 32'd0;
      r.fd_valid = tbl_has_fd[idx];
      return r;
   endfunction

   // Applies one transaction to the shadow table and returns the reply it should produce
   function automatic ght_reply_type predict_reply(input ght_cmd_type c);
      ght_reply_type r;
      int idx;
      int slot;
      r = '0;
      slot = 0;
      if (c.op == OP_ALLOC) begin
         for (idx = 1; idx < SLOTS && slot == 0; idx++)
            if (!tbl_used[idx]) slot = idx;
         if (slot == 0) begin
            r.status = STATUS_EXHAUSTED;
         end else begin
            tbl_used[slot] = 1'b1;
            tbl_kind[slot] = c.want_kind;
            tbl_rights[slot] = c.rights;
            tbl_fd[slot] = c.fd_present ? c.fd_value : 32'd0;
            tbl_has_fd[slot] = c.fd_present;
            r = slot_contents(slot);
         end
      end else if (c.op == OP_LOOKUP) begin
         slot = valid_slot(c.handle);
         if (slot == 0 || (c.check_kind && tbl_kind[slot] != c.want_kind))
            r.status = STATUS_BAD;
         else
            r = slot_contents(slot);
      end else if (c.op == OP_FREE) begin
         slot = valid_slot(c.handle);
         if (slot == 0) begin
            r.status = STATUS_BAD;
         end else begin
            r = slot_contents(slot);
            tbl_used[slot] = 1'b0;
            tbl_kind[slot] = '0;
            tbl_rights[slot] = '0;
            tbl_fd[slot] = '0;
            tbl_has_fd[slot] = 1'b0;
            tbl_gen[slot] = tbl_gen[slot] + 16'd1;
         end
      end else begin
         r.status = STATUS_BAD;
      end
      return r;
   endfunction

   // Mostly live handles taken from the shadow table; the rest is malformed or stale
   function automatic ght_cmd_type random_command(input bit filling);
      ght_cmd_type c;
      int pick;
      int sel;
      int idx;
      c.handle = $urandom();
      c.want_kind = 8'($urandom());
      c.check_kind = 1'($urandom_range(0, 1));
      c.rights = 16'($urandom());
      c.fd_value = $urandom();
      c.fd_present = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick >= 98)
         c.op = OP_UNKNOWN;
      else if (pick < (filling ? 70 : 10))
         c.op = OP_ALLOC;
      else if (pick < (filling ? 85 : 40))
         c.op = OP_LOOKUP;
      else
         c.op = OP_FREE;
      if (c.op != OP_ALLOC) begin
         sel = $urandom_range(0, 9);
         if (sel < 6 && live_q.size() > 0) begin
            idx = live_q[$urandom_range(0, live_q.size() - 1)];
            c.handle = {tbl_gen[idx], idx[15:0]};
            if ($urandom_range(0, 1)) c.want_kind = tbl_kind[idx];
         end else if (sel == 6) begin
            idx = $urandom_range(1, SLOTS - 1);
            c.handle = {tbl_gen[idx] - 16'd1, idx[15:0]};
         end else if (sel == 7) begin
            c.handle[15:0] = '0;
         end else if (sel == 8) begin
            c.handle[15:0] = 16'($urandom_range(SLOTS, 65535));
         end else if (sel == 9) begin
            idx = $urandom_range(1, SLOTS - 1);
            c.handle = {tbl_gen[idx], idx[15:0]};
         end
      end
      return c;
   endfunction

   task automatic queue_cmd(input logic [1:0] op, input logic [31:0] h, input logic [7:0] kind,
                            input logic chk, input logic [15:0] rights, input logic [31:0] fd,
                            input logic present);
      ght_cmd_type c;
      c.op = op;
      c.handle = h;
      c.want_kind = kind;
      c.check_kind = chk;
      c.rights = rights;
      c.fd_value = fd;
      c.fd_present = present;
      cmd_q.push_back(c);
   endtask

   task automatic wait_for_driver();
      @(negedge clock);
      while (cmd_q.size() != 0 || start) @(negedge clock);
   endtask

   task automatic collect_live_slots();
      int idx;
      live_q.delete();
      for (idx = 1; idx < SLOTS; idx++)
         if (tbl_used[idx]) live_q.push_back(idx);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         n_errors++;
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, name, exp_val, act_val);
      end
   endtask

   // Driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin : drive_proc
      ght_cmd_type c;
      logic nxt_start;
      nxt_start = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            reply_q.push_back(predict_reply(drv_cmd));
            n_accepted++;
         end
         if (start && busy) begin
            nxt_start = 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (cmd_q.size() > 0) begin
            c = cmd_q.pop_front();
            drv_cmd <= c;
            req_op <= c.op;
            req_handle <= c.handle;
            req_want_kind <= c.want_kind;
            req_check_kind <= c.check_kind;
            req_rights <= c.rights;
            req_fd_value <= c.fd_value;
            req_fd_present <= c.fd_present;
            nxt_start = 1'b1;
            if (!steady) begin
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         start <= nxt_start;
      end
   end

   always @(posedge clock) begin : monitor_proc
      ght_reply_type want;
      if (!reset && rsp_valid) begin
         case (rsp_status)
            STATUS_OK:        n_ok++;
            STATUS_EXHAUSTED: n_exhausted++;
            default:          n_bad++;
         endcase
         if (reply_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result: expected none, actual status %0d handle 0x%08h",
                     $time, rsp_status, rsp_handle_out);
         end else begin
            want = reply_q.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("handle_out", want.handle, rsp_handle_out);
            check_field("kind_out", 32'(want.kind), 32'(rsp_kind_out));
            check_field("rights_out", 32'(want.rights), 32'(rsp_rights_out));
            check_field("fd_out", want.fd, rsp_fd_out);
            check_field("fd_valid", 32'(want.fd_valid), 32'(rsp_fd_valid));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, reply_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus_proc
      int idx;
      int n;
      int k;
      int batch;
      bit filling;
      logic [15:0] slot1_gen;
      for (idx = 0; idx < SLOTS; idx++) begin
         tbl_used[idx] = 1'b0;
         tbl_gen[idx] = '0;
         tbl_kind[idx] = '0;
         tbl_rights[idx] = '0;
         tbl_fd[idx] = '0;
         tbl_has_fd[idx] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, every op, malformed and stale handles
      queue_cmd(OP_ALLOC, 32'hFFFF_FFFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(OP_ALLOC, 32'h0000_0000, 8'h00, 1'b0, 16'h0000, 32'h0000_0000, 1'b1);
      queue_cmd(OP_ALLOC, 32'h1234_5678, 8'h5A, 1'b0, 16'h1234, 32'hDEAD_BEEF, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0001, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0001, 8'hFF, 1'b1, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0001, 8'hFE, 1'b1, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0003, 8'h5A, 1'b1, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0000, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0100, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(OP_LOOKUP, 32'h0001_0002, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0004, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      // free ignores the kind even when asked to check it
      queue_cmd(OP_FREE, 32'h0000_0002, 8'h77, 1'b1, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_FREE, 32'h0000_0002, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0000_0002, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_LOOKUP, 32'h0001_0002, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_ALLOC, 32'h0, 8'h81, 1'b1, 16'h8001, 32'h8000_0001, 1'b1);
      queue_cmd(OP_LOOKUP, 32'h0001_0002, 8'h81, 1'b1, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_UNKNOWN, 32'h0000_0001, 8'hFF, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(OP_LOOKUP, 32'h0000_0001, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_FREE, 32'h0000_0001, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_FREE, 32'h0001_0002, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_FREE, 32'h0000_0003, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);
      queue_cmd(OP_FREE, 32'h0000_0000, 8'h00, 1'b0, 16'h0, 32'h0, 1'b0);

      // Random: alternate fill phases (driving the table to exhaustion) and drain phases
      n = 0;
      while (n < RANDOM_ITEMS) begin
         wait_for_driver();
         collect_live_slots();
         filling = (n % 800) < 500;
         batch = $urandom_range(1, 16);
         for (k = 0; k < batch; k++) begin
            cmd_q.push_back(random_command(filling));
            n++;
         end
      end

      // Release every live slot, then allocate and free slot 1 over and over
      wait_for_driver();
      collect_live_slots();
      foreach (live_q[k])
         queue_cmd(OP_FREE, {tbl_gen[live_q[k]], live_q[k][15:0]}, 8'($urandom()),
                   1'($urandom_range(0, 1)), 16'($urandom()), $urandom(),
                   1'($urandom_range(0, 1)));
      wait_for_driver();
      steady = 1'b1;
      slot1_gen = tbl_gen[1];
      for (k = 0; k < REUSE_PAIRS; k++) begin
         queue_cmd(OP_ALLOC, $urandom(), 8'($urandom()), 1'($urandom_range(0, 1)),
                   16'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
         queue_cmd(OP_FREE, {slot1_gen, 16'd1}, 8'($urandom()), 1'($urandom_range(0, 1)),
                   16'h0, 32'h0, 1'b0);
         slot1_gen = slot1_gen + 16'd1;
      end

      while (cmd_q.size() != 0 || start || reply_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (reply_q.size() != 0) begin
         n_errors++;
         $display("%0t: %0d expected results never arrived", $time, reply_q.size());
      end
      $display("Checked %0d transactions: %0d ok, %0d exhausted, %0d bad handle.",
               n_accepted, n_ok, n_exhausted, n_bad);
      $display("Covered field extremes, malformed and stale handles, table exhaustion, %s",
               "and back-to-back reuse of slot 1 across many generations.");
      if (n_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
